>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the throttle ramp block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define ETR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ETR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/etr_pkg.sv
// ----------------------------------------------------------------------------
// etr_pkg
// Types, constants and command encodings for the throttle ramp PWM block.
// ----------------------------------------------------------------------------
package etr_pkg;

  localparam int DUTY_BITS_DEF   = 14;
  localparam int DEMO_PERIOD_DEF = 8000;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int DEN_W      = 20;   // widest divisor: period_us

  localparam logic [15:0] FULL_THROTTLE = 16'hFFFF;
  localparam logic [15:0] DEMO_PEAK     = 16'd13107;

  localparam logic [15:0] MIN_PULSE_RST = 16'd1000;
  localparam logic [15:0] MAX_PULSE_RST = 16'd2000;
  localparam logic [19:0] PERIOD_RST    = 20'd20000;
  localparam logic [15:0] RAMP_RST      = 16'd200;

  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RAMP      = 2'd3;

  typedef enum logic [1:0] {
    MODE_CTRL       = 2'd0,
    MODE_DEMO       = 2'd1,
    MODE_STOP       = 2'd2,
    MODE_DEMO_START = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_RAMP, MUL_DEMO, MUL_SPAN, MUL_DUTY
  } mul_sel_t;

  typedef enum logic [2:0] {
    DIV_RAMP, DIV_PHASE, DIV_DEMO, DIV_SPAN, DIV_DUTY
  } div_sel_t;

  typedef enum logic [2:0] {
    LVL_KEEP, LVL_TARGET, LVL_STEP, LVL_DEMO, LVL_ZERO
  } lvl_sel_t;

  typedef enum logic [1:0] {
    PH_KEEP, PH_REM, PH_ZERO
  } phase_sel_t;

  typedef enum logic [1:0] {
    DUTY_KEEP, DUTY_FULL, DUTY_QUOT
  } duty_sel_t;

  typedef struct packed {
    logic       load_in;
    mul_sel_t   mul_sel;
    logic       div_start;
    div_sel_t   div_sel;
    lvl_sel_t   lvl_sel;
    phase_sel_t phase_sel;
    logic       pulse_ld;
    duty_sel_t  duty_sel;
    logic       out_ld;
  } etr_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  lvl_eq_tgt;
    logic  ramp_zero;
    logic  period_zero;
    logic  div_done;
  } etr_stat_t;

endpackage

>>> rtl/core/etr_div.sv
// ----------------------------------------------------------------------------
// etr_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etr_div #(
  parameter int NUM_W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  input  logic [etr_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [NUM_W-1:0]           quot,
  output logic [etr_pkg::DEN_W-1:0]  rem
);

  localparam int DW    = etr_pkg::DEN_W;
  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [NUM_W-1:0] q_r;
  logic [DW-1:0]    r_r;
  logic [DW-1:0]    d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DW:0]   r1, r2;
  logic          ge1, ge2;
  logic [DW-1:0] r1s, r2s;

  always_comb begin
    r1  = {r_r, q_r[NUM_W-1]};
    ge1 = (r1 >= {1'b0, d_r});
    r1s = ge1 ? DW'(r1 - {1'b0, d_r}) : r1[DW-1:0];
    r2  = {r1s, q_r[NUM_W-2]};
    ge2 = (r2 >= {1'b0, d_r});
    r2s = ge2 ? DW'(r2 - {1'b0, d_r}) : r2[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      r_r <= '0;
      d_r <= den;
    end else if (busy_r) begin
      q_r <= {q_r[NUM_W-3:0], ge1, ge2};
      r_r <= r2s;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

  `ETR_ASSERT(a_div_den_nonzero, busy_r |-> (d_r != '0), "divide by zero in progress")
  `ETR_ASSERT_NEXT(a_div_start_runs, start, busy_r, "divider did not start")

endmodule

>>> rtl/core/etr_datapath.sv
// ----------------------------------------------------------------------------
// etr_datapath
// Config registers, throttle state, shared multiplier and divider.
// ----------------------------------------------------------------------------
module etr_datapath #(
  parameter int DUTY_BITS   = etr_pkg::DUTY_BITS_DEF,
  parameter int DEMO_PERIOD = etr_pkg::DEMO_PERIOD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [etr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [etr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [1:0]                      in_mode,
  input  logic [15:0]                     in_elapsed_ms,
  input  logic [15:0]                     in_target_throttle,
  input  etr_pkg::etr_cmd_t               cmd,
  output etr_pkg::etr_stat_t              stat,
  output logic [DUTY_BITS-1:0]            out_duty,
  output logic [15:0]                     out_pulse_us,
  output logic [15:0]                     out_level
);

  localparam int BW      = (DUTY_BITS > 16) ? DUTY_BITS : 16;
  localparam int PW      = 16 + BW;
  localparam int NUM_RAW = (PW > 32) ? PW : 32;
  localparam int NUM_W   = NUM_RAW + (NUM_RAW % 2);
  localparam int PHASE_W = $clog2(DEMO_PERIOD);
  localparam int DW      = etr_pkg::DEN_W;

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;
  localparam logic [PHASE_W-1:0]   HALF_PH  = PHASE_W'(DEMO_PERIOD / 2);
  localparam logic [15:0]          PERIOD16 = 16'(DEMO_PERIOD);
  localparam logic [DW-1:0]        DEN_PER  = DW'(DEMO_PERIOD);
  localparam logic [DW-1:0]        DEN_HALF = DW'(DEMO_PERIOD / 2);

  logic [15:0]          min_r, max_r, ramp_r;
  logic [19:0]          period_r;
  logic [15:0]          level_r, level_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [1:0]           mode_r;
  logic [15:0]          dt_r, target_r;
  logic [NUM_W-1:0]     prod_r;
  logic [15:0]          pulse_r;
  logic [DUTY_BITS-1:0] duty_r;
  logic [DUTY_BITS-1:0] out_duty_r;
  logic [15:0]          out_pulse_r, out_level_r;

  logic [15:0]      span;
  logic [15:0]      demo_x;
  logic [15:0]      mul_a;
  logic [BW-1:0]    mul_b;
  logic [PW-1:0]    mul_p;
  logic [16:0]      phase_sum;
  logic [NUM_W-1:0] div_num;
  logic [DW-1:0]    div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;
  logic [DW-1:0]    div_rem;
  logic [15:0]      lvl_gap;
  logic             tgt_above;
  logic             step_hit;

  assign span      = (max_r > min_r) ? (max_r - min_r) : '0;
  assign demo_x    = (phase_r < HALF_PH) ? 16'(phase_r) : (PERIOD16 - 16'(phase_r));
  assign phase_sum = 17'(phase_r) + 17'(dt_r);
  assign tgt_above = (target_r > level_r);
  assign lvl_gap   = tgt_above ? (target_r - level_r) : (level_r - target_r);
  assign step_hit  = (NUM_W'(lvl_gap) <= div_quot);

  always_comb begin
    case (cmd.mul_sel)
      etr_pkg::MUL_RAMP: begin
        mul_a = etr_pkg::FULL_THROTTLE;
        mul_b = BW'(dt_r);
      end
      etr_pkg::MUL_DEMO: begin
        mul_a = etr_pkg::DEMO_PEAK;
        mul_b = BW'(demo_x);
      end
      etr_pkg::MUL_SPAN: begin
        mul_a = span;
        mul_b = BW'(level_r);
      end
      etr_pkg::MUL_DUTY: begin
        mul_a = pulse_r;
        mul_b = BW'(DUTY_MAX);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    div_num = prod_r;
    case (cmd.div_sel)
      etr_pkg::DIV_RAMP:  div_den = DW'(ramp_r);
      etr_pkg::DIV_PHASE: begin
        div_num = NUM_W'(phase_sum);
        div_den = DEN_PER;
      end
      etr_pkg::DIV_DEMO:  div_den = DEN_HALF;
      etr_pkg::DIV_SPAN:  div_den = DW'(etr_pkg::FULL_THROTTLE);
      default:            div_den = period_r;
    endcase
  end

  etr_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_comb begin
    case (cmd.lvl_sel)
      etr_pkg::LVL_TARGET: level_nxt = target_r;
      etr_pkg::LVL_STEP: begin
        if (step_hit) begin
          level_nxt = target_r;
        end else if (tgt_above) begin
          level_nxt = level_r + div_quot[15:0];
        end else begin
          level_nxt = level_r - div_quot[15:0];
        end
      end
      etr_pkg::LVL_DEMO:   level_nxt = div_quot[15:0];
      etr_pkg::LVL_ZERO:   level_nxt = '0;
      default:             level_nxt = level_r;
    endcase
    case (cmd.phase_sel)
      etr_pkg::PH_REM:  phase_nxt = div_rem[PHASE_W-1:0];
      etr_pkg::PH_ZERO: phase_nxt = '0;
      default:          phase_nxt = phase_r;
    endcase
  end

  // config and throttle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= etr_pkg::MIN_PULSE_RST;
      max_r    <= etr_pkg::MAX_PULSE_RST;
      period_r <= etr_pkg::PERIOD_RST;
      ramp_r   <= etr_pkg::RAMP_RST;
      level_r  <= '0;
      phase_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          etr_pkg::CFG_MIN_PULSE: min_r    <= cfg_wdata[15:0];
          etr_pkg::CFG_MAX_PULSE: max_r    <= cfg_wdata[15:0];
          etr_pkg::CFG_PERIOD:    period_r <= cfg_wdata[19:0];
          etr_pkg::CFG_RAMP:      ramp_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      level_r <= level_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r   <= in_mode;
      dt_r     <= in_elapsed_ms;
      target_r <= in_target_throttle;
    end
    if (cmd.mul_sel != etr_pkg::MUL_NONE) begin
      prod_r <= NUM_W'(mul_p);
    end
    if (cmd.pulse_ld) begin
      pulse_r <= min_r + div_quot[15:0];
    end
    case (cmd.duty_sel)
      etr_pkg::DUTY_FULL: duty_r <= DUTY_MAX;
      etr_pkg::DUTY_QUOT: duty_r <= (div_quot > NUM_W'(DUTY_MAX)) ? DUTY_MAX
                                                                  : div_quot[DUTY_BITS-1:0];
      default: ;
    endcase
    if (cmd.out_ld) begin
      out_duty_r  <= duty_r;
      out_pulse_r <= pulse_r;
      out_level_r <= level_r;
    end
  end

  assign stat.mode        = etr_pkg::mode_t'(mode_r);
  assign stat.lvl_eq_tgt  = (level_r == target_r);
  assign stat.ramp_zero   = (ramp_r == '0);
  assign stat.period_zero = (period_r == '0);
  assign stat.div_done    = div_done;

  assign out_duty     = out_duty_r;
  assign out_pulse_us = out_pulse_r;
  assign out_level    = out_level_r;

endmodule

>>> rtl/core/etr_ctrl.sv
// ----------------------------------------------------------------------------
// etr_ctrl
// Sequencer: steps one tick through ramp/demo, pulse and duty divisions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  etr_pkg::etr_stat_t  stat,
  output etr_pkg::etr_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RAMP_MUL, S_RAMP_DIV, S_DEMO_DIV, S_DEMO_MUL,
    S_DEMO_LVL, S_SPAN_MUL, S_SPAN_DIV, S_DUTY_MUL, S_DUTY_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   div_run_r, div_run_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = etr_pkg::DIV_DUTY;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.mode)
          etr_pkg::MODE_CTRL: begin
            if (stat.lvl_eq_tgt) begin
              state_nxt = S_SPAN_MUL;
            end else if (stat.ramp_zero) begin
              cmd.lvl_sel = etr_pkg::LVL_TARGET;
              state_nxt   = S_SPAN_MUL;
            end else begin
              state_nxt = S_RAMP_MUL;
            end
          end
          etr_pkg::MODE_DEMO: state_nxt = S_DEMO_DIV;
          etr_pkg::MODE_STOP: begin
            cmd.lvl_sel = etr_pkg::LVL_ZERO;
            state_nxt   = S_SPAN_MUL;
          end
          etr_pkg::MODE_DEMO_START: begin
            cmd.phase_sel = etr_pkg::PH_ZERO;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_RAMP_MUL: begin
        cmd.mul_sel = etr_pkg::MUL_RAMP;
        state_nxt   = S_RAMP_DIV;
      end
      S_RAMP_DIV: begin
        cmd.div_sel   = etr_pkg::DIV_RAMP;
        cmd.div_start = !div_run_r;
        if (stat.div_done) begin
          cmd.lvl_sel = etr_pkg::LVL_STEP;
          state_nxt   = S_SPAN_MUL;
        end
      end
      S_DEMO_DIV: begin
        // new phase = (phase + dt) mod period
        cmd.div_sel   = etr_pkg::DIV_PHASE;
        cmd.div_start = !div_run_r;
        if (stat.div_done) begin
          cmd.phase_sel = etr_pkg::PH_REM;
          state_nxt     = S_DEMO_MUL;
        end
      end
      S_DEMO_MUL: begin
        cmd.mul_sel = etr_pkg::MUL_DEMO;
        state_nxt   = S_DEMO_LVL;
      end
      S_DEMO_LVL: begin
        cmd.div_sel   = etr_pkg::DIV_DEMO;
        cmd.div_start = !div_run_r;
        if (stat.div_done) begin
          cmd.lvl_sel = etr_pkg::LVL_DEMO;
          state_nxt   = S_SPAN_MUL;
        end
      end
      S_SPAN_MUL: begin
        cmd.mul_sel = etr_pkg::MUL_SPAN;
        state_nxt   = S_SPAN_DIV;
      end
      S_SPAN_DIV: begin
        cmd.div_sel   = etr_pkg::DIV_SPAN;
        cmd.div_start = !div_run_r;
        if (stat.div_done) begin
          cmd.pulse_ld = 1'b1;
          state_nxt    = S_DUTY_MUL;
        end
      end
      S_DUTY_MUL: begin
        cmd.mul_sel = etr_pkg::MUL_DUTY;
        if (stat.period_zero) begin
          cmd.duty_sel = etr_pkg::DUTY_FULL;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_DUTY_DIV;
        end
      end
      S_DUTY_DIV: begin
        cmd.div_sel   = etr_pkg::DIV_DUTY;
        cmd.div_start = !div_run_r;
        if (stat.div_done) begin
          cmd.duty_sel = etr_pkg::DUTY_QUOT;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    div_run_nxt = div_run_r;
    if (cmd.div_start) begin
      div_run_nxt = 1'b1;
    end else if (stat.div_done) begin
      div_run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_run_r   <= div_run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `ETR_ASSERT(a_out_no_overwrite, cmd.out_ld |-> (!out_valid_r || out_tready), "pending result overwritten")
  `ETR_ASSERT(a_div_done_owned, stat.div_done |-> div_run_r, "divider done without request")

endmodule

>>> rtl/core/esc_throttle_ramp_pwm.sv
// ----------------------------------------------------------------------------
// esc_throttle_ramp_pwm
// Throttle slew limiter with servo-pulse to PWM duty conversion.
// ----------------------------------------------------------------------------
// One request is one tick. Control, demo and stop ticks each give one result
// (duty, pulse width, level); a demo start tick clears the demo phase and
// gives none. Ticks are handled one at a time. The shared divider retires
// two quotient bits per cycle. A stop tick needs two divisions, a control
// tick up to three, a demo tick four; a zero period drops the duty division.
// A result waits in the output register while the next tick is taken.
module esc_throttle_ramp_pwm #(
  parameter int DUTY_BITS   = etr_pkg::DUTY_BITS_DEF,
  parameter int DEMO_PERIOD = etr_pkg::DEMO_PERIOD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [etr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [etr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // elapsed_ms, target_throttle
  input  logic [1:0]                      in_tuser,   // mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((DUTY_BITS+32+7)/8)*8-1:0] out_tdata // duty, pulse_us, level
);

  localparam int OUT_W = ((DUTY_BITS + 32 + 7) / 8) * 8;

  etr_pkg::etr_cmd_t  cmd;
  etr_pkg::etr_stat_t stat;

  logic [DUTY_BITS-1:0] duty;
  logic [15:0]          pulse_us;
  logic [15:0]          level;

  etr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  etr_datapath #(
    .DUTY_BITS   (DUTY_BITS),
    .DEMO_PERIOD (DEMO_PERIOD)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_tuser),
    .in_elapsed_ms      (in_tdata[15:0]),
    .in_target_throttle (in_tdata[31:16]),
    .cmd                (cmd),
    .stat               (stat),
    .out_duty           (duty),
    .out_pulse_us       (pulse_us),
    .out_level          (level)
  );

  assign out_tdata = OUT_W'({level, pulse_us, duty});

endmodule
